@@ rtl/wav_header_parser_defines.svh @@
// Assertion macros for the WAV header parser.
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define WHP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WHP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WHP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define WHP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/whp_pkg.sv @@
package whp_pkg;
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_FMT    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CTL_RUN  = 2'd0,
    CTL_DIV  = 2'd1,
    CTL_OUT  = 2'd2
  } ctl_state_t;

  typedef enum logic [1:0] {
    TAG_OTHER = 2'd0,
    TAG_FMT   = 2'd1,
    TAG_DATA  = 2'd2
  } tag_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF = 3'd1;
  localparam logic [2:0] ST_SHORT_FMT = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;
  localparam logic [2:0] ST_UNSUPP  = 3'd5;

  localparam logic [31:0] TAG_RIFF_LE = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE_LE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT_LE  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA_LE = 32'h6174_6164;

  localparam int DivSteps = 32;

  typedef struct packed {
    logic take;
    logic last;
    logic div_start;
    logic div_step;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;
endpackage

@@ rtl/whp_if.sv @@
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] sample_rate;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic        float_format;
  logic [31:0] payload_offset;
  logic [31:0] payload_size;
  logic [30:0] frame_count;
  modport source (output valid, status, sample_rate, channel_count, sample_bits,
                  float_format, payload_offset, payload_size, frame_count,
                  input ready);
  modport sink (input valid, status, sample_rate, channel_count, sample_bits,
                float_format, payload_offset, payload_size, frame_count,
                output ready);
endinterface

@@ rtl/whp_datapath.sv @@
module whp_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  whp_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        data_byte,
  output whp_pkg::dp_stat_t stat,
  output logic [2:0]        status,
  output logic [31:0]       sample_rate,
  output logic [15:0]       channel_count,
  output logic [15:0]       sample_bits,
  output logic              float_format,
  output logic [31:0]       payload_offset,
  output logic [31:0]       payload_size,
  output logic [30:0]       frame_count
);
  import whp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] shift_r, shift_nxt, sh;
  tag_t        tag_r, tag_nxt;
  logic [31:0] skip_r, skip_nxt, skip_dec;
  logic [31:0] pos_r, pos_nxt;
  logic [15:0] p_tag_r, p_tag_nxt, p_ch_r, p_ch_nxt, p_bits_r, p_bits_nxt;
  logic [31:0] p_rate_r, p_rate_nxt;
  logic [31:0] h_rate_r, h_rate_nxt, h_off_r, h_off_nxt, h_size_r, h_size_nxt;
  logic [15:0] h_ch_r, h_ch_nxt, h_bits_r, h_bits_nxt;
  logic        h_float_r, h_float_nxt;
  logic [1:0]  found_r, found_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        need_r, need_nxt;
  // divider
  logic [31:0] quo_r, rem_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic [32:0] trial;
  logic [31:0] divisor;

  assign sh = {data_byte, shift_r[31:8]};
  assign skip_dec = (skip_r != 32'd0) ? skip_r - 32'd1 : 32'd0;

  always_comb begin
    phase_nxt = phase_r; idx_nxt = idx_r; shift_nxt = shift_r; tag_nxt = tag_r;
    skip_nxt = skip_r; pos_nxt = pos_r;
    p_tag_nxt = p_tag_r; p_ch_nxt = p_ch_r; p_rate_nxt = p_rate_r; p_bits_nxt = p_bits_r;
    h_rate_nxt = h_rate_r; h_ch_nxt = h_ch_r; h_bits_nxt = h_bits_r;
    h_float_nxt = h_float_r; h_off_nxt = h_off_r; h_size_nxt = h_size_r;
    found_nxt = found_r; err_nxt = err_r;
    if (cmd.take && phase_r != PH_ERROR) begin
      if (pos_r != 32'hFFFF_FFFF) pos_nxt = pos_r + 32'd1;
      unique case (phase_r)
        PH_HEADER: begin
          shift_nxt = sh;
          idx_nxt = idx_r + 4'd1;
          if (idx_r == 4'd3 && sh != TAG_RIFF_LE) begin
            err_nxt = ST_BAD_RIFF; phase_nxt = PH_ERROR;
          end else if (idx_r == 4'd11) begin
            if (sh != TAG_WAVE_LE) begin
              err_nxt = ST_BAD_RIFF; phase_nxt = PH_ERROR;
            end else begin
              idx_nxt = 4'd0; shift_nxt = 32'd0; phase_nxt = PH_CHUNK;
            end
          end
        end
        PH_CHUNK: begin
          shift_nxt = sh;
          idx_nxt = idx_r + 4'd1;
          if (idx_r == 4'd3) begin
            if (sh == TAG_FMT_LE) tag_nxt = TAG_FMT;
            else if (sh == TAG_DATA_LE) tag_nxt = TAG_DATA;
            else tag_nxt = TAG_OTHER;
          end
          if (idx_r == 4'd7) begin
            idx_nxt = 4'd0; shift_nxt = 32'd0;
            if (tag_r == TAG_FMT) begin
              skip_nxt = (sh > 32'd16) ? sh - 32'd16 : 32'd0;
              phase_nxt = PH_FMT;
            end else begin
              if (tag_r == TAG_DATA) begin
                h_off_nxt = pos_nxt; h_size_nxt = sh; found_nxt[1] = 1'b1;
              end
              skip_nxt = sh;
              phase_nxt = (sh != 32'd0) ? PH_SKIP : PH_CHUNK;
            end
          end
        end
        PH_FMT: begin
          idx_nxt = idx_r + 4'd1;
          case (idx_r)
            4'd0: p_tag_nxt[7:0] = data_byte;
            4'd1: p_tag_nxt[15:8] = data_byte;
            4'd2: p_ch_nxt[7:0] = data_byte;
            4'd3: p_ch_nxt[15:8] = data_byte;
            4'd4: p_rate_nxt[7:0] = data_byte;
            4'd5: p_rate_nxt[15:8] = data_byte;
            4'd6: p_rate_nxt[23:16] = data_byte;
            4'd7: p_rate_nxt[31:24] = data_byte;
            4'd14: p_bits_nxt[7:0] = data_byte;
            4'd15: p_bits_nxt[15:8] = data_byte;
            default: ;
          endcase
          if (idx_r == 4'd15) begin
            h_rate_nxt = p_rate_r; h_ch_nxt = p_ch_r;
            h_bits_nxt = {data_byte, p_bits_r[7:0]};
            h_float_nxt = (p_tag_r == 16'd3);
            found_nxt[0] = 1'b1;
            p_tag_nxt = '0; p_ch_nxt = '0; p_rate_nxt = '0; p_bits_nxt = '0;
            idx_nxt = 4'd0; shift_nxt = 32'd0;
            phase_nxt = (skip_r != 32'd0) ? PH_SKIP : PH_CHUNK;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            idx_nxt = 4'd0; shift_nxt = 32'd0; phase_nxt = PH_CHUNK;
          end
        end
        default: ;
      endcase
    end
  end

  // final status from next-state values
  always_comb begin
    logic [2:0] e;
    e = err_nxt;
    need_nxt = 1'b0;
    if (e == ST_OK && phase_nxt == PH_HEADER) e = ST_BAD_RIFF;
    else if (e == ST_OK && phase_nxt == PH_FMT) e = ST_SHORT_FMT;
    if (e != ST_OK) st_nxt = e;
    else if (found_nxt != 2'b11) st_nxt = ST_MISSING;
    else if (h_ch_nxt == 16'd0 || h_rate_nxt == 32'd0) st_nxt = ST_ZERO;
    else if ((h_float_nxt && h_bits_nxt == 16'd32) || h_bits_nxt == 16'd16) begin
      st_nxt = ST_OK; need_nxt = 1'b1;
    end else st_nxt = ST_UNSUPP;
  end

  assign divisor = (h_bits_r == 16'd16) ? {15'd0, h_ch_r, 1'b0} : {14'd0, h_ch_r, 2'b0};
  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      phase_r <= PH_HEADER; idx_r <= '0; shift_r <= '0; tag_r <= TAG_OTHER;
      skip_r <= '0; pos_r <= '0;
      p_tag_r <= '0; p_ch_r <= '0; p_rate_r <= '0; p_bits_r <= '0;
      h_rate_r <= '0; h_ch_r <= '0; h_bits_r <= '0; h_float_r <= 1'b0;
      h_off_r <= '0; h_size_r <= '0; found_r <= '0; err_r <= '0;
      st_r <= '0; need_r <= 1'b0; cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; shift_r <= shift_nxt; tag_r <= tag_nxt;
      skip_r <= skip_nxt; pos_r <= pos_nxt;
      p_tag_r <= p_tag_nxt; p_ch_r <= p_ch_nxt; p_rate_r <= p_rate_nxt;
      p_bits_r <= p_bits_nxt;
      h_rate_r <= h_rate_nxt; h_ch_r <= h_ch_nxt; h_bits_r <= h_bits_nxt;
      h_float_r <= h_float_nxt; h_off_r <= h_off_nxt; h_size_r <= h_size_nxt;
      found_r <= found_nxt; err_r <= err_nxt;
      if (cmd.take && cmd.last) begin
        st_r <= st_nxt; need_r <= need_nxt;
      end
      if (cmd.div_start) cnt_r <= 6'(DivSteps);
      else if (cmd.div_step && cnt_r != 6'd0) cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && cmd.last) quo_r <= '0;
    if (cmd.div_start) begin
      quo_r <= h_size_r; rem_r <= '0; dvs_r <= divisor;
    end else if (cmd.div_step && cnt_r != 6'd0) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0]; quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], quo_r[31]}; quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign stat.need_div = need_r;
  assign stat.div_done = (cnt_r == 6'd1);
  assign status = st_r;
  assign sample_rate = h_rate_r;
  assign channel_count = h_ch_r;
  assign sample_bits = h_bits_r;
  assign float_format = h_float_r;
  assign payload_offset = h_off_r;
  assign payload_size = h_size_r;
  assign frame_count = need_r ? quo_r[30:0] : 31'd0;
endmodule

@@ rtl/whp_ctrl.sv @@
module whp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  whp_pkg::dp_stat_t stat,
  output whp_pkg::dp_cmd_t  cmd
);
  import whp_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       dstart_r, dstart_nxt;

  always_comb begin
    state_nxt = state_r;
    dstart_nxt = 1'b0;
    unique case (state_r)
      CTL_RUN: if (in_valid && in_last) begin
        state_nxt = CTL_DIV; dstart_nxt = 1'b1;
      end
      CTL_DIV: if (!dstart_r && (!stat.need_div || stat.div_done)) state_nxt = CTL_OUT;
      CTL_OUT: if (out_ready) state_nxt = CTL_RUN;
      default: state_nxt = CTL_RUN;
    endcase
  end

  always_comb begin
    in_ready = (state_r == CTL_RUN);
    out_valid = (state_r == CTL_OUT);
    cmd.take = in_valid && (state_r == CTL_RUN);
    cmd.last = in_last;
    cmd.div_start = dstart_r;
    cmd.div_step = (state_r == CTL_DIV);
    cmd.clear = (state_r == CTL_OUT) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_RUN; dstart_r <= 1'b0;
    end else begin
      state_r <= state_nxt; dstart_r <= dstart_nxt;
    end
  end
endmodule

@@ rtl/wav_header_parser.sv @@
// channel  dir  payload
// in       sink data_byte[8], last_byte
// out      src  status, fmt fields, payload info, frame_count
// One byte per cycle while parsing. On the last byte the frame count comes
// from a radix-2 divider that runs in the divide state before out_valid
// rises; when status is not ok out_valid does not wait for the divider.
// No byte is taken from the last byte until the result beat is taken.
// Synchronous active-low reset returns to the RIFF header phase.
`include "wav_header_parser_defines.svh"
module wav_header_parser (
  input logic clk,
  input logic rst_n,
  whp_in_if.sink    in_ch,
  whp_out_if.source out_ch
);
  import whp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  whp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_last(in_ch.last_byte), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  whp_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_ch.data_byte), .stat,
    .status(out_ch.status), .sample_rate(out_ch.sample_rate),
    .channel_count(out_ch.channel_count), .sample_bits(out_ch.sample_bits),
    .float_format(out_ch.float_format), .payload_offset(out_ch.payload_offset),
    .payload_size(out_ch.payload_size), .frame_count(out_ch.frame_count)
  );

  `WHP_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)
  `WHP_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.last_byte, !in_ch.ready)
  `WHP_ASSERT_IMPL(a_frames_ok, clk, rst_n, out_ch.valid && out_ch.status != ST_OK, out_ch.frame_count == 31'd0)
endmodule

@@ dv/wav_header_parser_test.sv @@
module wav_header_parser_test;
  import whp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic        float_format;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
    logic [30:0] frame_count;
  } summary_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       has_known;
    summary_t   known;
  } dir_row_t;

  logic clk;
  logic rst_n;
  whp_in_if  in_ch();
  whp_out_if out_ch();

  wav_header_parser u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // predictor state
  phase_t      p_phase;
  logic [3:0]  p_idx;
  logic [31:0] p_shift;
  tag_t        p_tag;
  logic [31:0] p_skip;
  logic [31:0] p_pos;
  logic [31:0] pend_rate;
  logic [15:0] pend_ch, pend_bits, pend_fmt;
  logic [31:0] h_rate, h_off, h_size;
  logic [15:0] h_ch, h_bits;
  logic        h_float;
  logic [1:0]  p_found;
  logic [2:0]  p_err;

  summary_t   summary_q[$];
  logic       known_q[$];
  summary_t   known_val_q[$];
  int         errors;
  int         idle_cycles;
  bit         stim_done;
  bit         long_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic parser_reset();
    p_phase = PH_HEADER; p_idx = '0; p_shift = '0; p_tag = TAG_OTHER;
    p_skip = '0; p_pos = '0; pend_rate = '0; pend_ch = '0; pend_bits = '0;
    pend_fmt = '0; h_rate = '0; h_off = '0; h_size = '0; h_ch = '0;
    h_bits = '0; h_float = 1'b0; p_found = '0; p_err = ST_OK;
  endtask

  task automatic body_done();
    p_idx = '0;
    p_shift = '0;
    p_phase = (p_skip != 0) ? PH_SKIP : PH_CHUNK;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    if (p_phase == PH_ERROR) return;
    if (p_pos != 32'hFFFF_FFFF) p_pos++;
    case (p_phase)
      PH_HEADER: begin
        p_shift = {b, p_shift[31:8]};
        if (p_idx == 3 && p_shift != TAG_RIFF_LE) begin
          p_err = ST_BAD_RIFF; p_phase = PH_ERROR;
        end else if (p_idx == 11) begin
          if (p_shift != TAG_WAVE_LE) begin
            p_err = ST_BAD_RIFF; p_phase = PH_ERROR;
          end else begin
            p_idx = '0; p_shift = '0; p_phase = PH_CHUNK;
          end
        end else p_idx++;
      end
      PH_CHUNK: begin
        p_shift = {b, p_shift[31:8]};
        if (p_idx == 3) begin
          if (p_shift == TAG_FMT_LE) p_tag = TAG_FMT;
          else if (p_shift == TAG_DATA_LE) p_tag = TAG_DATA;
          else p_tag = TAG_OTHER;
        end
        if (p_idx == 7) begin
          if (p_tag == TAG_FMT) begin
            p_skip = (p_shift > 16) ? p_shift - 16 : 0;
            p_idx = '0; p_shift = '0; p_phase = PH_FMT;
          end else begin
            if (p_tag == TAG_DATA) begin
              h_off = p_pos; h_size = p_shift; p_found[1] = 1'b1;
            end
            p_skip = p_shift;
            body_done();
          end
        end else p_idx++;
      end
      PH_FMT: begin
        if (p_idx < 2) pend_fmt[8*p_idx +: 8] = b;
        else if (p_idx < 4) pend_ch[8*(p_idx-2) +: 8] = b;
        else if (p_idx < 8) pend_rate[8*(p_idx-4) +: 8] = b;
        else if (p_idx >= 14) pend_bits[8*(p_idx-14) +: 8] = b;
        if (p_idx == 15) begin
          h_rate = pend_rate; h_ch = pend_ch; h_bits = pend_bits;
          h_float = (pend_fmt == 16'd3); p_found[0] = 1'b1;
          pend_rate = '0; pend_ch = '0; pend_bits = '0; pend_fmt = '0;
          body_done();
        end else p_idx++;
      end
      default: begin
        if (p_skip != 0) p_skip--;
        if (p_skip == 0) body_done();
      end
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    summary_t s;
    logic [31:0] div;
    parse_byte(b);
    if (!last) return;
    if (p_err == ST_OK) begin
      if (p_phase == PH_HEADER) p_err = ST_BAD_RIFF;
      else if (p_phase == PH_FMT) p_err = ST_SHORT_FMT;
    end
    s = '0;
    if (p_err != ST_OK) s.status = p_err;
    else if (p_found != 2'b11) s.status = ST_MISSING;
    else if (h_ch == 0 || h_rate == 0) s.status = ST_ZERO;
    else if ((h_float && h_bits == 32) || h_bits == 16) begin
      div = h_ch * (h_bits / 8);
      s.status = ST_OK;
      s.frame_count = (div != 0) ? 31'(h_size / div) : '0;
    end else s.status = ST_UNSUPP;
    s.sample_rate = h_rate; s.channel_count = h_ch; s.sample_bits = h_bits;
    s.float_format = h_float; s.payload_offset = h_off; s.payload_size = h_size;
    summary_q.push_back(s);
    parser_reset();
  endtask

  // stimulus byte list
  logic [7:0] bytes_q[$];
  logic       lasts_q[$];
  logic       known_flag_q[$];
  summary_t   known_row_q[$];

  task automatic put(input logic [7:0] b, input logic last = 1'b0);
    bytes_q.push_back(b); lasts_q.push_back(last);
    known_flag_q.push_back(1'b0); known_row_q.push_back('0);
  endtask

  task automatic put32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) put(w[8*i +: 8]);
  endtask

  task automatic seal_file();
    lasts_q[$] = 1'b1;
  endtask

  task automatic put_fmt(input logic [15:0] fmt, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits,
                         input logic [31:0] size);
    logic [31:0] extra;
    put32(TAG_FMT_LE); put32(size);
    put(fmt[7:0]); put(fmt[15:8]); put(ch[7:0]); put(ch[15:8]);
    put32(rate);
    for (int i = 0; i < 6; i++) put(8'($urandom));
    put(bits[7:0]); put(bits[15:8]);
    extra = (size > 16) ? size - 16 : 0;
    for (int i = 0; i < extra; i++) put(8'($urandom));
  endtask

  task automatic put_other(input int n);
    put32($urandom); put32(n);
    for (int i = 0; i < n; i++) put(8'($urandom));
  endtask

  task automatic put_data(input logic [31:0] size, input int body);
    put32(TAG_DATA_LE); put32(size);
    for (int i = 0; i < body; i++) put(8'($urandom));
  endtask

  task automatic random_file();
    int kind, nchunk;
    logic [15:0] bits;
    kind = $urandom_range(0, 9);
    put32(TAG_RIFF_LE); put32($urandom); put32(TAG_WAVE_LE);
    if (kind == 0) begin
      for (int i = 0; i < $urandom_range(1, 20); i++) put(8'($urandom));
      bytes_q[bytes_q.size() - $urandom_range(1, 12)] ^= 8'(1 << $urandom_range(0, 7));
    end else begin
      nchunk = $urandom_range(1, 4);
      for (int c = 0; c < nchunk; c++) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            case ($urandom_range(0, 3))
              0: bits = 16;
              1: bits = 32;
              2: bits = 8;
              default: bits = 16'($urandom);
            endcase
            put_fmt(($urandom_range(0, 1)) ? 16'd3 : 16'($urandom_range(0, 4)),
                    16'($urandom_range(0, 3)), ($urandom_range(0, 7) == 0) ? 0 : $urandom,
                    bits, $urandom_range(10, 22));
          end
          2, 3: begin
            if ($urandom_range(0, 1)) put_data($urandom_range(0, 24), 0);
            else begin
              kind = $urandom_range(0, 12);
              put_data(kind, kind);
            end
          end
          4: put_other($urandom_range(0, 6));
          default: put(8'($urandom));
        endcase
      end
      if ($urandom_range(0, 5) == 0)
        for (int i = 0; i < $urandom_range(1, 6); i++) void'(bytes_q.pop_back());
    end
    if (bytes_q.size() == 0) put(8'($urandom));
    while (lasts_q.size() > bytes_q.size()) begin
      void'(lasts_q.pop_back()); void'(known_flag_q.pop_back());
      void'(known_row_q.pop_back());
    end
    seal_file();
  endtask

  task automatic build_directed();
    summary_t s;
    dir_row_t rows[$];
    // one-byte files: bad header
    s = '0; s.status = ST_BAD_RIFF;
    rows.push_back('{8'hFF, 1'b1, 1'b1, s});
    rows.push_back('{8'h00, 1'b1, 1'b1, s});
    // wrong RIFF tag, then frozen
    rows.push_back('{8'h52, 1'b0, 1'b0, '0});
    rows.push_back('{8'h49, 1'b0, 1'b0, '0});
    rows.push_back('{8'h46, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h46, 1'b1, 1'b1, s});
    foreach (rows[i]) begin
      bytes_q.push_back(rows[i].data_byte); lasts_q.push_back(rows[i].last_byte);
      known_flag_q.push_back(rows[i].has_known); known_row_q.push_back(rows[i].known);
    end
    // header only: missing chunk
    put32(TAG_RIFF_LE); put32(32'hFFFF_FFFF); put32(TAG_WAVE_LE); seal_file();
    // truncated fmt body
    put32(TAG_RIFF_LE); put32(0); put32(TAG_WAVE_LE);
    put32(TAG_FMT_LE); put32(16); put(8'h01); put(8'h00, 1'b1);
    // full 16-bit pcm, small fmt size, odd data size
    put32(TAG_RIFF_LE); put32(0); put32(TAG_WAVE_LE);
    put_fmt(16'h0001, 16'h0002, 32'd48000, 16'd16, 2);
    put_other(3); put_data(7, 7); seal_file();
    // float 32, extremes, big skip past end
    put32(TAG_RIFF_LE); put32(0); put32(TAG_WAVE_LE);
    put_fmt(16'h0003, 16'hFFFF, 32'hFFFF_FFFF, 16'd32, 20);
    put_data(32'hFFFF_FFFF, 4); seal_file();
    // zero channels, unsupported
    put32(TAG_RIFF_LE); put32(0); put32(TAG_WAVE_LE);
    put_fmt(16'h0001, 16'h0000, 32'd8000, 16'd16, 16); put_data(0, 0); seal_file();
    put32(TAG_RIFF_LE); put32(0); put32(TAG_WAVE_LE);
    put_fmt(16'hFFFF, 16'h0001, 32'd8000, 16'd24, 16); put_data(9, 0);
    put32(TAG_DATA_LE); put(8'h01); seal_file();
  endtask

  // sender
  initial begin
    int burst;
    errors = 0; stim_done = 1'b0; long_stall = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.data_byte = '0; in_ch.last_byte = 1'b0;
    parser_reset();
    build_directed();
    while (bytes_q.size() < 1925) random_file();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst = $urandom_range(1, 40);
    while (bytes_q.size() > 0) begin
      if (burst == 0 && $urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= bytes_q[0];
      in_ch.last_byte <= lasts_q[0];
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      predict_byte(bytes_q[0], lasts_q[0]);
      if (lasts_q[0]) begin
        known_q.push_back(known_flag_q[0]);
        known_val_q.push_back(known_row_q[0]);
      end
      void'(bytes_q.pop_front()); void'(lasts_q.pop_front());
      void'(known_flag_q.pop_front()); void'(known_row_q.pop_front());
      if (burst > 0) burst--;
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver
  initial begin
    int beats;
    out_ch.ready = 1'b0;
    beats = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (beats == 3 && !long_stall) begin
        long_stall = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_ch.ready <= ((beats % 16) < 6) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_ch.valid && out_ch.ready) beats++;
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    summary_t exp_s, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.sample_rate, out_ch.channel_count,
              out_ch.sample_bits, out_ch.float_format, out_ch.payload_offset,
              out_ch.payload_size, out_ch.frame_count};
      if (summary_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_s = summary_q.pop_front();
        if (known_q.pop_front()) begin
          if (known_val_q[0] != exp_s) begin
            $error("table row disagrees with predictor");
            errors++;
          end
        end
        void'(known_val_q.pop_front());
        if (got.status != exp_s.status) begin
          $error("status exp %0d got %0d", exp_s.status, got.status); errors++;
        end
        if (got.sample_rate != exp_s.sample_rate) begin
          $error("sample_rate exp %0h got %0h", exp_s.sample_rate, got.sample_rate);
          errors++;
        end
        if (got.channel_count != exp_s.channel_count) begin
          $error("channel_count exp %0h got %0h", exp_s.channel_count,
                 got.channel_count);
          errors++;
        end
        if (got.sample_bits != exp_s.sample_bits) begin
          $error("sample_bits exp %0h got %0h", exp_s.sample_bits, got.sample_bits);
          errors++;
        end
        if (got.float_format != exp_s.float_format) begin
          $error("float_format exp %0d got %0d", exp_s.float_format, got.float_format);
          errors++;
        end
        if (got.payload_offset != exp_s.payload_offset) begin
          $error("payload_offset exp %0h got %0h", exp_s.payload_offset,
                 got.payload_offset);
          errors++;
        end
        if (got.payload_size != exp_s.payload_size) begin
          $error("payload_size exp %0h got %0h", exp_s.payload_size, got.payload_size);
          errors++;
        end
        if (got.frame_count != exp_s.frame_count) begin
          $error("frame_count exp %0h got %0h", exp_s.frame_count, got.frame_count);
          errors++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (stim_done && summary_q.size() == 0) begin
        repeat (60) @(posedge clk);
        if (errors == 0 && summary_q.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule
